[design/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master pin sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int          QUEUE_DEPTH       = 2;
    localparam int          PADDR_W           = 3;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd8;
    localparam logic [0:0]  REG_HALF_PERIOD   = 1'b0;
    localparam int          MSB_BIT           = 7;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_STOP_A    = 4'd3,
        PH_STOP_B    = 4'd4,
        PH_WR_CLKLO  = 4'd5,
        PH_WR_SETBIT = 4'd6,
        PH_WR_HIGH   = 4'd7,
        PH_WR_LOW    = 4'd8,
        PH_ACK_DATA  = 4'd9,
        PH_ACK_HIGH  = 4'd10,
        PH_ACK_LOW   = 4'd11,
        PH_RD_PRE    = 4'd12,
        PH_RD_HIGH   = 4'd13,
        PH_RD_LOW    = 4'd14,
        PH_RD_ACKDRV = 4'd15
    } t_phase;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       dropped;
    } t_out_item;

    typedef struct packed {
        t_cmd       op;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_in;
    } t_op;

endpackage

[design/i2cm_fifo.sv]
// ----------------------------------------------------------------------------
// i2cm_fifo
// Small register queue with count-based full and empty flags.
// ----------------------------------------------------------------------------
module i2cm_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/i2cm_front.sv]
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick items, decodes the command kind and queues them for the
// sequencer engine.
// ----------------------------------------------------------------------------
module i2cm_front #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  i2cm_pkg::t_in_item i_item,
    input  logic              i_op_pop,
    output i2cm_pkg::t_op     o_op,
    output logic              o_op_empty
);
    import i2cm_pkg::*;

    t_op w_op;

    always_comb begin
        w_op.write_byte = i_item.write_byte;
        w_op.send_ack   = i_item.send_ack;
        w_op.sda_in     = i_item.sda_in;
        case (i_item.kind)
            CMD_START: w_op.op = CMD_START;
            CMD_STOP:  w_op.op = CMD_STOP;
            CMD_WRITE: w_op.op = CMD_WRITE;
            CMD_READ:  w_op.op = CMD_READ;
            default:   w_op.op = CMD_NONE;
        endcase
    end

    i2cm_fifo #(
        .DEPTH (DEPTH),
        .WIDTH ($bits(t_op))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_op),
        .o_full  (full),
        .i_pop   (i_op_pop),
        .o_data  (o_op),
        .o_empty (o_op_empty)
    );

endmodule

[design/i2cm_regs.sv]
// ----------------------------------------------------------------------------
// i2cm_regs
// APB-style configuration register holding the half period in ticks.
// ----------------------------------------------------------------------------
module i2cm_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [i2cm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [15:0]                  o_half_period
);
    import i2cm_pkg::*;

    logic [15:0] r_half_period;
    logic [0:0]  w_index;
    logic        w_hit;

    assign pready        = 1'b1;
    assign w_index       = paddr[PADDR_W-1 -: 1];
    assign w_hit         = (w_index == REG_HALF_PERIOD);
    assign o_half_period = r_half_period;
    assign prdata        = w_hit ? {16'd0, r_half_period} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_half_period <= pwdata[15:0];
        end
    end

endmodule

[design/i2cm_engine.sv]
// ----------------------------------------------------------------------------
// i2cm_engine
// Pin sequencer: steps SCL and SDA through the start, stop, write and read
// phases, one queued tick per cycle while a tick is queued and the result queue has room.
// ----------------------------------------------------------------------------
module i2cm_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2cm_pkg::t_op       i_op,
    input  logic                i_op_valid,
    input  logic                i_res_full,
    input  logic [15:0]         i_half_period,
    output logic                o_fire,
    output i2cm_pkg::t_out_item o_res
);
    import i2cm_pkg::*;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  bit_count;
        logic [7:0]  shift_data;
        logic [15:0] wait_count;
        logic        scl;
        logic        sda;
        logic        sda_en;
        logic        ack;
        logic [7:0]  last_read;
    } t_eng;

    t_eng        r_st;
    t_eng        n_st;
    t_eng        w_entry;
    logic        w_drop;
    logic [15:0] w_dly;

    function automatic t_eng f_enter(t_eng s, t_phase p, logic [15:0] dly);
        t_eng t;
        t            = s;
        t.phase      = p;
        t.wait_count = 16'd1;
        case (p)
            PH_START_A: begin
                t.scl = 1'b1; t.sda = 1'b1; t.wait_count = dly;
            end
            PH_START_B: begin
                t.sda = 1'b0; t.wait_count = dly;
            end
            PH_STOP_A: begin
                t.scl = 1'b1; t.sda = 1'b0; t.wait_count = dly;
            end
            PH_STOP_B: begin
                t.sda = 1'b1; t.wait_count = dly;
            end
            PH_WR_CLKLO:  t.scl = 1'b0;
            PH_WR_SETBIT: t.sda = t.shift_data[MSB_BIT];
            PH_WR_HIGH: begin
                t.scl = 1'b1; t.wait_count = dly;
            end
            PH_WR_LOW:    t.scl = 1'b0;
            PH_ACK_DATA:  t.wait_count = dly;
            PH_ACK_HIGH: begin
                t.scl = 1'b1; t.wait_count = dly;
            end
            PH_ACK_LOW:   t.scl = 1'b0;
            PH_RD_PRE:    t.scl = 1'b0;
            PH_RD_HIGH: begin
                t.scl = 1'b1; t.wait_count = dly;
            end
            PH_RD_LOW:    t.scl = 1'b0;
            PH_RD_ACKDRV: t.sda_en = 1'b1;
            default: begin
                t.phase = PH_IDLE; t.wait_count = 16'd0; t.bit_count = 4'd0;
            end
        endcase
        return t;
    endfunction

    assign o_fire = i_op_valid && !i_res_full;
    assign w_dly  = (i_half_period == 16'd0) ? 16'd1 : i_half_period;

    // next state
    always_comb begin
        t_eng s;
        s      = r_st;
        w_drop = 1'b0;
        if (s.phase == PH_IDLE) begin
            if (i_op.op != CMD_NONE) begin
                s.bit_count = 4'd0;
                case (i_op.op)
                    CMD_START: s = f_enter(s, PH_START_A, w_dly);
                    CMD_STOP:  s = f_enter(s, PH_STOP_A, w_dly);
                    CMD_WRITE: begin
                        s.shift_data = i_op.write_byte;
                        s = f_enter(s, PH_WR_CLKLO, w_dly);
                    end
                    default: begin
                        s.ack        = i_op.send_ack;
                        s.shift_data = 8'd0;
                        s = f_enter(s, PH_RD_PRE, w_dly);
                    end
                endcase
            end
        end else if (i_op.op != CMD_NONE) begin
            w_drop = 1'b1;
        end
        w_entry = s;
        if (s.phase != PH_IDLE) begin
            if (s.phase == PH_RD_HIGH && s.wait_count == 16'd1) begin
                s.shift_data = {s.shift_data[6:0], i_op.sda_in};
            end
            if (s.wait_count != 16'd0) begin
                s.wait_count = s.wait_count - 16'd1;
            end
            if (s.wait_count == 16'd0) begin
                case (s.phase)
                    PH_START_A:   s = f_enter(s, PH_START_B, w_dly);
                    PH_STOP_A:    s = f_enter(s, PH_STOP_B, w_dly);
                    PH_WR_CLKLO:  s = f_enter(s, PH_WR_SETBIT, w_dly);
                    PH_WR_SETBIT: s = f_enter(s, PH_WR_HIGH, w_dly);
                    PH_WR_HIGH:   s = f_enter(s, PH_WR_LOW, w_dly);
                    PH_WR_LOW: begin
                        s.shift_data = {s.shift_data[6:0], 1'b0};
                        s.bit_count  = s.bit_count + 4'd1;
                        if (s.bit_count >= 4'd8) begin
                            s.bit_count = 4'd0;
                            s.sda       = 1'b1;
                            s = f_enter(s, PH_ACK_DATA, w_dly);
                        end else begin
                            s = f_enter(s, PH_WR_SETBIT, w_dly);
                        end
                    end
                    PH_ACK_DATA:  s = f_enter(s, PH_ACK_HIGH, w_dly);
                    PH_ACK_HIGH:  s = f_enter(s, PH_ACK_LOW, w_dly);
                    PH_RD_PRE: begin
                        if (s.bit_count == 4'd0) begin
                            s.sda_en = 1'b0; s.bit_count = 4'd1; s.wait_count = 16'd1;
                        end else if (s.bit_count == 4'd1) begin
                            s.sda = 1'b1; s.bit_count = 4'd2; s.wait_count = 16'd1;
                        end else begin
                            s.bit_count  = 4'd0;
                            s.shift_data = 8'd0;
                            s = f_enter(s, PH_RD_HIGH, w_dly);
                        end
                    end
                    PH_RD_HIGH:   s = f_enter(s, PH_RD_LOW, w_dly);
                    PH_RD_LOW: begin
                        s.bit_count = s.bit_count + 4'd1;
                        if (s.bit_count >= 4'd8) begin
                            s.bit_count = 4'd0;
                            s.last_read = s.shift_data;
                            s = f_enter(s, PH_RD_ACKDRV, w_dly);
                        end else begin
                            s = f_enter(s, PH_RD_HIGH, w_dly);
                        end
                    end
                    PH_RD_ACKDRV: begin
                        s.sda = !s.ack;
                        s = f_enter(s, PH_ACK_DATA, w_dly);
                    end
                    default:      s = f_enter(s, PH_IDLE, w_dly);
                endcase
            end
        end
        n_st = s;
    end

    // outputs
    always_comb begin
        o_res.scl       = w_entry.scl;
        o_res.sda_out   = w_entry.sda;
        o_res.sda_drive = w_entry.sda_en;
        o_res.busy_res  = (w_entry.phase != PH_IDLE);
        o_res.done_res  = (w_entry.phase != PH_IDLE) && (n_st.phase == PH_IDLE);
        o_res.read_byte = n_st.last_read;
        o_res.dropped   = w_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase      <= PH_IDLE;
            r_st.bit_count  <= 4'd0;
            r_st.shift_data <= 8'd0;
            r_st.wait_count <= 16'd0;
            r_st.scl        <= 1'b1;
            r_st.sda        <= 1'b1;
            r_st.sda_en     <= 1'b1;
            r_st.ack        <= 1'b0;
            r_st.last_read  <= 8'd0;
        end else if (o_fire) begin
            r_st <= n_st;
        end
    end

endmodule

[design/i2c_master_pin_sequencer_core.sv]
// Path: an accepted tick transaction waits in the input queue; the engine takes
// it when the result queue has room and writes its result there for popping.
// Throughput: one tick per cycle while the result queue has room, set by the
// engine's phase update; queues on both sides absorb stalls.
// Reset: synchronous active-low; queues empty, sequencer idle with SCL, SDA
// high and driven, half period back to 8 ticks.
// ----------------------------------------------------------------------------
// i2c_master_pin_sequencer_core
// I2C master pin sequencer: front decoder and queue, sequencer engine,
// result queue and configuration register.
// ----------------------------------------------------------------------------
module i2c_master_pin_sequencer_core #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  i2cm_pkg::t_in_item           i_item,
    output logic                         empty,
    input  logic                         pop,
    output i2cm_pkg::t_out_item          o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [i2cm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import i2cm_pkg::*;

    t_op         w_op;
    logic        w_op_empty;
    logic        w_fire;
    logic        w_res_full;
    t_out_item   w_res;
    logic [15:0] w_half_period;

    i2cm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .i_op_pop   (w_fire),
        .o_op       (w_op),
        .o_op_empty (w_op_empty)
    );

    i2cm_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_half_period (w_half_period)
    );

    i2cm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .i_op_valid    (!w_op_empty),
        .i_res_full    (w_res_full),
        .i_half_period (w_half_period),
        .o_fire        (w_fire),
        .o_res         (w_res)
    );

    i2cm_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_out_item))
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

[design/i2cm_checker.sv]
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master pin sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input i2cm_pkg::t_out_item o_result
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed");

    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.done_res |-> o_result.busy_res)
        else $error("done outside a command sequence");

    a_drop_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.dropped |-> o_result.busy_res)
        else $error("command dropped while idle");

endmodule

bind i2c_master_pin_sequencer_core i2cm_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

[bench/i2c_master_pin_sequencer_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_pin_sequencer_core_test
// Feeds tick transactions carrying start, stop, write and read commands
// through the input queue. Each accepted tick is run through a tick-exact
// model of the pin sequencer, and every popped result is compared with the
// predicted pin levels, status flags and read byte. The half period is set
// through the APB port between phases and while a command runs, with zero
// and full scale among the settings; random stalls sit on both queue sides.
// ----------------------------------------------------------------------------
module i2c_master_pin_sequencer_core_test;

    import i2cm_pkg::*;

    localparam logic [PADDR_W-1:0] HALF_PERIOD_ADDR = {REG_HALF_PERIOD, 2'b00};
    localparam logic [PADDR_W-1:0] UNUSED_ADDR      = 3'd4;
    localparam int                 HOLD_CYCLES      = 200;
    localparam int                 PHASE_TICKS      = 85;
    localparam int                 MAX_REPORTS      = 10;

    class pin_level_scoreboard;
        t_out_item   expected_pins[$];
        int          faults;
        logic [15:0] half_per;
        t_phase      phase;
        logic [3:0]  bit_cnt;
        logic [7:0]  shreg;
        logic [15:0] wait_cnt;
        logic        scl;
        logic        sda;
        logic        sda_en;
        logic        ack_sel;
        logic [7:0]  last_rd;

        function new();
            faults   = 0;
            half_per = HALF_PERIOD_RESET;
            phase    = PH_IDLE;
            bit_cnt  = '0;
            shreg    = '0;
            wait_cnt = '0;
            scl      = 1'b1;
            sda      = 1'b1;
            sda_en   = 1'b1;
            ack_sel  = 1'b0;
            last_rd  = '0;
        endfunction

        function logic [15:0] delay_len();
            return (half_per == 16'd0) ? 16'd1 : half_per;
        endfunction

        function void enter_phase(t_phase p);
            phase    = p;
            wait_cnt = 16'd1;
            case (p)
                PH_START_A: begin
                    scl = 1'b1; sda = 1'b1; wait_cnt = delay_len();
                end
                PH_START_B: begin
                    sda = 1'b0; wait_cnt = delay_len();
                end
                PH_STOP_A: begin
                    scl = 1'b1; sda = 1'b0; wait_cnt = delay_len();
                end
                PH_STOP_B: begin
                    sda = 1'b1; wait_cnt = delay_len();
                end
                PH_WR_CLKLO:  scl = 1'b0;
                PH_WR_SETBIT: sda = shreg[MSB_BIT];
                PH_WR_HIGH: begin
                    scl = 1'b1; wait_cnt = delay_len();
                end
                PH_WR_LOW:    scl = 1'b0;
                PH_ACK_DATA:  wait_cnt = delay_len();
                PH_ACK_HIGH: begin
                    scl = 1'b1; wait_cnt = delay_len();
                end
                PH_ACK_LOW:   scl = 1'b0;
                PH_RD_PRE:    scl = 1'b0;
                PH_RD_HIGH: begin
                    scl = 1'b1; wait_cnt = delay_len();
                end
                PH_RD_LOW:    scl = 1'b0;
                PH_RD_ACKDRV: sda_en = 1'b1;
                default: begin
                    phase = PH_IDLE; wait_cnt = '0; bit_cnt = '0;
                end
            endcase
        endfunction

        function void advance_phase();
            case (phase)
                PH_START_A:   enter_phase(PH_START_B);
                PH_STOP_A:    enter_phase(PH_STOP_B);
                PH_WR_CLKLO:  enter_phase(PH_WR_SETBIT);
                PH_WR_SETBIT: enter_phase(PH_WR_HIGH);
                PH_WR_HIGH:   enter_phase(PH_WR_LOW);
                PH_WR_LOW: begin
                    shreg   = shreg << 1;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8) begin
                        bit_cnt = '0;
                        sda     = 1'b1;
                        enter_phase(PH_ACK_DATA);
                    end else begin
                        enter_phase(PH_WR_SETBIT);
                    end
                end
                PH_ACK_DATA:  enter_phase(PH_ACK_HIGH);
                PH_ACK_HIGH:  enter_phase(PH_ACK_LOW);
                PH_RD_PRE: begin
                    if (bit_cnt == 4'd0) begin
                        sda_en = 1'b0; bit_cnt = 4'd1; wait_cnt = 16'd1;
                    end else if (bit_cnt == 4'd1) begin
                        sda = 1'b1; bit_cnt = 4'd2; wait_cnt = 16'd1;
                    end else begin
                        bit_cnt = '0; shreg = '0;
                        enter_phase(PH_RD_HIGH);
                    end
                end
                PH_RD_HIGH:   enter_phase(PH_RD_LOW);
                PH_RD_LOW: begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8) begin
                        bit_cnt = '0;
                        last_rd = shreg;
                        enter_phase(PH_RD_ACKDRV);
                    end else begin
                        enter_phase(PH_RD_HIGH);
                    end
                end
                PH_RD_ACKDRV: begin
                    sda = ack_sel ? 1'b0 : 1'b1;
                    enter_phase(PH_ACK_DATA);
                end
                default:      enter_phase(PH_IDLE);
            endcase
        endfunction

        function bit is_idle();
            return phase == PH_IDLE;
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

        function void set_reg(logic [PADDR_W-1:0] addr, logic [31:0] value);
            if (addr == HALF_PERIOD_ADDR) begin
                half_per = value[15:0];
            end
        endfunction

        function void note_tick(t_in_item it);
            t_out_item r;
            bit        is_cmd;
            r      = '0;
            is_cmd = (it.kind >= CMD_START) && (it.kind <= CMD_READ);
            if (phase == PH_IDLE) begin
                if (is_cmd) begin
                    bit_cnt = '0;
                    case (it.kind)
                        CMD_START: enter_phase(PH_START_A);
                        CMD_STOP:  enter_phase(PH_STOP_A);
                        CMD_WRITE: begin
                            shreg = it.write_byte;
                            enter_phase(PH_WR_CLKLO);
                        end
                        default: begin
                            ack_sel = it.send_ack;
                            shreg   = '0;
                            enter_phase(PH_RD_PRE);
                        end
                    endcase
                end
            end else if (is_cmd) begin
                r.dropped = 1'b1;
            end
            r.scl       = scl;
            r.sda_out   = sda;
            r.sda_drive = sda_en;
            if (phase != PH_IDLE) begin
                r.busy_res = 1'b1;
                if (phase == PH_RD_HIGH && wait_cnt == 16'd1) begin
                    shreg = {shreg[6:0], it.sda_in};
                end
                if (wait_cnt > 16'd0) begin
                    wait_cnt = wait_cnt - 16'd1;
                end
                if (wait_cnt == 16'd0) begin
                    advance_phase();
                    if (phase == PH_IDLE) begin
                        r.done_res = 1'b1;
                    end
                end
            end
            r.read_byte = last_rd;
            expected_pins.push_back(r);
        endfunction

        function void check_pins(t_out_item got);
            t_out_item exp;
            if (expected_pins.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS) begin
                    $display("unexpected result transaction: %h", got);
                end
                return;
            end
            exp = expected_pins.pop_front();
            if (got !== exp) begin
                faults++;
                if (faults <= MAX_REPORTS) begin
                    $display({"pin mismatch (exp/got): scl %b/%b sda %b/%b drive %b/%b ",
                              "busy %b/%b done %b/%b read %h/%h dropped %b/%b"},
                             exp.scl, got.scl, exp.sda_out, got.sda_out,
                             exp.sda_drive, got.sda_drive, exp.busy_res, got.busy_res,
                             exp.done_res, got.done_res, exp.read_byte, got.read_byte,
                             exp.dropped, got.dropped);
                end
            end
        endfunction

        function void check_reg(logic [15:0] exp, logic [15:0] got);
            if (got !== exp) begin
                faults++;
                if (faults <= MAX_REPORTS) begin
                    $display("half period readback mismatch: exp %h got %h", exp, got);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    t_in_item             i_item;
    logic                 empty;
    logic                 pop;
    t_out_item            o_result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    pin_level_scoreboard  sb;
    bit                   tx_fast;
    bit                   rx_fast;
    bit                   rx_hold_req;
    int                   seq_step;
    int                   seq_len;
    int                   tick_total;

    i2c_master_pin_sequencer_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function t_in_item random_tick(logic [2:0] kind);
        t_in_item it;
        it.kind       = kind;
        it.write_byte = 8'($urandom);
        it.send_ack   = 1'($urandom);
        it.sda_in     = 1'($urandom);
        return it;
    endfunction

    function logic [2:0] next_kind();
        int r;
        r = $urandom_range(0, 99);
        if (!sb.is_idle()) begin
            if (r < 5) return 3'($urandom_range(CMD_START, CMD_READ));
            if (r < 8) return 3'($urandom_range(5, 7));
            return CMD_NONE;
        end
        if (r < 20) return CMD_NONE;
        if (r < 28) return 3'($urandom_range(0, 7));
        case (seq_step)
            0: begin
                seq_step = 1;
                seq_len  = $urandom_range(1, 3);
                return CMD_START;
            end
            1: begin
                seq_step = 2;
                return CMD_WRITE;
            end
            default: begin
                if (seq_len > 0) begin
                    seq_len--;
                    return $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
                end
                seq_step = 0;
                return CMD_STOP;
            end
        endcase
    endfunction

    task automatic send_tick(t_in_item it);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_tick(it);
        tick_total++;
    endtask

    task automatic run_cmd(t_cmd op, logic [7:0] data, logic ack, int sda_fix);
        t_in_item it;
        it = random_tick(op);
        it.write_byte = data;
        it.send_ack   = ack;
        send_tick(it);
        while (!sb.is_idle()) begin
            it = random_tick(CMD_NONE);
            if (sda_fix >= 0) begin
                it.sda_in = sda_fix[0];
            end
            send_tick(it);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(addr, data);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == HALF_PERIOD_ADDR) begin
            sb.check_reg(sb.half_per, prdata[15:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side
    initial begin
        int gap;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = rx_fast ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_pins(o_result);
        end
    end

    initial begin
        logic [15:0] hp_list [6];
        int          phase_ticks;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_item      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_fast     = 1'b0;
        rx_fast     = 1'b0;
        rx_hold_req = 1'b0;
        seq_step    = 0;
        seq_len     = 0;
        tick_total  = 0;
        sb          = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: shortest half period, byte extremes, ack and nack reads
        reg_write(HALF_PERIOD_ADDR, 32'd1);
        run_cmd(CMD_START, 8'h00, 1'b0, -1);
        run_cmd(CMD_WRITE, 8'h00, 1'b0, -1);
        run_cmd(CMD_WRITE, 8'hFF, 1'b1, -1);
        run_cmd(CMD_READ, 8'h00, 1'b1, 1);
        run_cmd(CMD_READ, 8'hFF, 1'b0, 0);
        run_cmd(CMD_READ, 8'h5A, 1'b1, -1);
        run_cmd(CMD_STOP, 8'h00, 1'b0, -1);
        send_tick(random_tick(3'd5));
        send_tick(random_tick(3'd7));
        // a write starts, and commands sent while it is busy are dropped
        send_tick(random_tick(CMD_WRITE));
        send_tick(random_tick(CMD_START));
        send_tick(random_tick(CMD_READ));
        send_tick(random_tick(3'd6));
        run_cmd(CMD_STOP, 8'h00, 1'b0, -1);
        drain();

        // zero half period behaves as one
        reg_write(HALF_PERIOD_ADDR, 32'd0);
        run_cmd(CMD_START, 8'h00, 1'b0, -1);
        run_cmd(CMD_WRITE, 8'hA5, 1'b0, -1);
        run_cmd(CMD_STOP, 8'h00, 1'b0, -1);
        drain();

        // full scale half period, idle ticks only
        reg_write(HALF_PERIOD_ADDR, 32'hFFFF_FFFF);
        send_tick(random_tick(CMD_NONE));
        send_tick(random_tick(3'd5));
        drain();
        reg_write(UNUSED_ADDR, 32'h0000_0003);
        reg_write(HALF_PERIOD_ADDR, 32'd2);
        // register change while a command is running
        run_cmd(CMD_START, 8'h00, 1'b0, -1);
        send_tick(random_tick(CMD_WRITE));
        send_tick(random_tick(CMD_NONE));
        drain();
        reg_write(HALF_PERIOD_ADDR, 32'd4);
        while (!sb.is_idle()) send_tick(random_tick(CMD_NONE));
        run_cmd(CMD_STOP, 8'h00, 1'b0, -1);
        drain();

        hp_list[0] = 16'd2;
        hp_list[1] = 16'd1;
        hp_list[2] = 16'd0;
        hp_list[3] = 16'd3;
        hp_list[4] = 16'd8;
        hp_list[5] = 16'($urandom_range(1, 4));
        for (int p = 0; p < 6; p++) begin
            reg_write(HALF_PERIOD_ADDR, {16'($urandom), hp_list[p]});
            tx_fast = (p == 1) || (p == 2);
            rx_fast = (p == 2) || (p == 4);
            if (p == 1) begin
                rx_hold_req = 1'b1;
            end
            phase_ticks = 0;
            while (phase_ticks < PHASE_TICKS || tick_total < 125 * (p + 1)) begin
                send_tick(random_tick(next_kind()));
                phase_ticks++;
            end
            drain();
        end

        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
design/i2cm_pkg.sv
design/i2cm_fifo.sv
design/i2cm_front.sv
design/i2cm_regs.sv
design/i2cm_engine.sv
design/i2c_master_pin_sequencer_core.sv
design/i2cm_checker.sv
bench/i2c_master_pin_sequencer_core_test.sv
